FILE: rtl/rgbh_pkg.sv
package rgbh_pkg;

    // Number of quotient bits produced by the divider chain, one per cell.
    localparam int QBITS = 9;
    // Width of the dividend fed into each divider lane.
    localparam int NBITS = 17;
    // Channel width.
    localparam int CBITS = 8;

    localparam logic [QBITS-1:0] HUE_WRAP = 9'd360;

    // One restoring divider lane: partial remainder, the dividend bits still
    // to be brought down (with quotient bits shifting in behind them), and
    // the divisor.
    typedef struct packed {
        logic [CBITS-1:0] rem;
        logic [QBITS-1:0] bits;
        logic [CBITS-1:0] div;
    } t_lane;

    // Everything that travels from one cell to the next.
    typedef struct packed {
        logic             valid;
        logic             gray;
        logic [CBITS-1:0] brightness;
        t_lane            hue;
        t_lane            sat;
    } t_stage;

    // One restoring division step.
    function automatic t_lane div_step(input t_lane lane);
        logic [CBITS:0] trial;
        logic [CBITS:0] diff;
        t_lane          res;
        trial = {lane.rem, lane.bits[QBITS-1]};
        diff  = trial - {1'b0, lane.div};
        res   = lane;
        if (trial >= {1'b0, lane.div}) begin
            res.rem  = diff[CBITS-1:0];
            res.bits = {lane.bits[QBITS-2:0], 1'b1};
        end else begin
            res.rem  = trial[CBITS-1:0];
            res.bits = {lane.bits[QBITS-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

FILE: rtl/rgbh_prep.sv
module rgbh_prep (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    output rgbh_pkg::t_stage      o_stage
);
    import rgbh_pkg::*;

    logic [CBITS-1:0] mx;
    logic [CBITS-1:0] mn;
    logic [CBITS-1:0] delta;
    logic [CBITS-1:0] adiff;
    logic             neg;
    logic [NBITS-1:0] base;
    logic [NBITS-1:0] step;
    logic [NBITS-1:0] hue_num;
    logic [NBITS-1:0] sat_num;
    t_stage           n_stage;
    t_stage           r_stage;

    always_comb begin
        // Ties go to red first, then green.
        if (i_red >= i_green && i_red >= i_blue) begin
            mx = i_red;
            if (i_green >= i_blue) begin
                neg   = 1'b0;
                adiff = i_green - i_blue;
            end else begin
                neg   = 1'b1;
                adiff = i_blue - i_green;
            end
        end else if (i_green >= i_blue) begin
            mx = i_green;
            if (i_blue >= i_red) begin
                neg   = 1'b0;
                adiff = i_blue - i_red;
            end else begin
                neg   = 1'b1;
                adiff = i_red - i_blue;
            end
        end else begin
            mx = i_blue;
            if (i_red >= i_green) begin
                neg   = 1'b0;
                adiff = i_red - i_green;
            end else begin
                neg   = 1'b1;
                adiff = i_green - i_red;
            end
        end

        if (i_red <= i_green && i_red <= i_blue) begin
            mn = i_red;
        end else if (i_green <= i_blue) begin
            mn = i_green;
        end else begin
            mn = i_blue;
        end

        delta = mx - mn;
        step  = NBITS'(adiff) * NBITS'(60);

        // Base angle times delta; a negative offset from red wraps via 360.
        if (mx == i_red) begin
            base = neg ? NBITS'(delta) * NBITS'(360) : '0;
        end else if (mx == i_green) begin
            base = NBITS'(delta) * NBITS'(120);
        end else begin
            base = NBITS'(delta) * NBITS'(240);
        end

        hue_num = neg ? (base - step) : (base + step);
        // Saturation dividend is doubled so both lanes yield nine quotient bits.
        sat_num = NBITS'(delta) * NBITS'(510);

        n_stage.valid      = i_valid;
        n_stage.gray       = (delta == '0);
        n_stage.brightness = mx;
        n_stage.hue.rem    = hue_num[NBITS-1:QBITS];
        n_stage.hue.bits   = hue_num[QBITS-1:0];
        n_stage.hue.div    = delta;
        n_stage.sat.rem    = sat_num[NBITS-1:QBITS];
        n_stage.sat.bits   = sat_num[QBITS-1:0];
        n_stage.sat.div    = mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

FILE: rtl/rgbh_cell.sv
module rgbh_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rgbh_pkg::t_stage i_stage,
    output rgbh_pkg::t_stage o_stage
);
    import rgbh_pkg::*;

    t_stage n_stage;
    t_stage r_stage;

    always_comb begin
        n_stage     = i_stage;
        n_stage.hue = div_step(i_stage.hue);
        n_stage.sat = div_step(i_stage.sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

FILE: rtl/rgb_to_hsv_converter.sv
// RGB to HSV converter for 8-bit pixels.
//
// A request is presented on i_red, i_green and i_blue with start held high;
// it is taken at any rising edge where start is high and busy is low. busy
// is low at all times outside reset, so a new pixel may be issued on every
// clock and the block sustains one pixel per cycle.
//
// Each result appears on o_hue, o_saturation, o_brightness and o_gray for
// exactly one cycle, marked by o_strobe. Results leave in request order.
// The receiver cannot stall the block and must take every result in the
// cycle it is shown.
//
// The pipeline is a prep register that finds the largest and smallest
// channels and forms both dividends, nine cells that each produce one
// quotient bit for the hue and saturation divisions together, and one
// output register that wraps the hue and zeroes gray pixels.
//
// While i_rst_n is low busy is high, every in-flight request is dropped and
// o_strobe stays low; the block is ready again in the cycle reset is released.
module rgb_to_hsv_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_strobe,
    output logic [8:0] o_hue,
    output logic [7:0] o_saturation,
    output logic [7:0] o_brightness,
    output logic       o_gray
);
    import rgbh_pkg::*;

    t_stage           w_link [0:QBITS];
    t_stage           w_last;
    logic [QBITS-1:0] hue_q;
    logic             n_strobe;
    logic [8:0]       n_hue;
    logic [7:0]       n_saturation;
    logic             r_strobe;
    logic [8:0]       r_hue;
    logic [7:0]       r_saturation;
    logic [7:0]       r_brightness;
    logic             r_gray;

    // The pipeline never holds back a request; only reset makes it unready.
    assign busy = ~i_rst_n;

    rgbh_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_stage (w_link[0])
    );

    // Each cell brings down one dividend bit in both lanes.
    for (genvar k = 0; k < QBITS; k++) begin : g_cell
        rgbh_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_link[k]),
            .o_stage (w_link[k+1])
        );
    end

    assign w_last = w_link[QBITS];
    assign hue_q  = w_last.hue.bits;

    always_comb begin
        n_strobe = w_last.valid;
        if (w_last.gray) begin
            n_hue        = '0;
            n_saturation = '0;
        end else begin
            n_hue        = (hue_q >= HUE_WRAP) ? (hue_q - HUE_WRAP) : hue_q;
            // The saturation dividend was doubled, so drop the extra bit.
            n_saturation = w_last.sat.bits[QBITS-1:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
        r_hue        <= n_hue;
        r_saturation <= n_saturation;
        r_brightness <= w_last.brightness;
        r_gray       <= w_last.gray;
    end

    assign o_strobe     = r_strobe;
    assign o_hue        = r_hue;
    assign o_saturation = r_saturation;
    assign o_brightness = r_brightness;
    assign o_gray       = r_gray;

endmodule

FILE: rtl/rgbh_checker.sv
module rgbh_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic [8:0] o_hue,
    input logic [7:0] o_saturation,
    input logic       o_gray
);

    localparam int LATENCY = 11;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised outside reset");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("request produced no result after the pipeline latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("result shown without a matching request");

    a_gray_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_gray) |-> (o_hue == 9'd0 && o_saturation == 8'd0))
        else $error("gray pixel with nonzero hue or saturation");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_hue < 9'd360))
        else $error("hue out of range");

endmodule

bind rgb_to_hsv_converter rgbh_checker u_rgbh_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_hue        (o_hue),
    .o_saturation (o_saturation),
    .o_gray       (o_gray)
);
